// ----- src/opl2rwp_pkg.sv -----
// Shared types, constants and decode functions for the OPL2 register-write profiler.
// No dependencies; imported by the interfaces, the counter bank and the top level.
`default_nettype none

package opl2rwp_pkg;

  localparam int unsigned AddrW       = 8;
  localparam int unsigned DataW       = 8;
  localparam int unsigned ChanW       = 4;
  localparam int unsigned OutCountW   = 32;
  localparam int unsigned NumRegs     = 256;
  localparam int unsigned NumChannels = 9;
  localparam int unsigned NumCounters = 9;
  localparam int unsigned NumGroups   = 5;

  // Counter slots, in result order
  localparam int unsigned CntNoteOn  = 0;
  localparam int unsigned CntPitch   = 1;
  localparam int unsigned CntLive    = 2;
  localparam int unsigned CntGroup0  = 3;
  localparam int unsigned CntRhythm  = 8;

  // Register map of the sound chip
  localparam logic [AddrW-1:0] AddrOp1Lo    = 8'h20;
  localparam logic [AddrW-1:0] AddrOp1Hi    = 8'h95;
  localparam logic [AddrW-1:0] AddrOp2Lo    = 8'he0;
  localparam logic [AddrW-1:0] AddrOp2Hi    = 8'hf5;
  localparam logic [AddrW-1:0] AddrPitchLo  = 8'ha0;
  localparam logic [AddrW-1:0] AddrKeyLo    = 8'hb0;
  localparam logic [AddrW-1:0] AddrKeyHi    = 8'hb8;
  localparam logic [AddrW-1:0] AddrRhythm   = 8'hbd;
  localparam logic [DataW-1:0] RhythmMask   = 8'h3f;
  localparam int unsigned      KeyOnBit     = 5;
  localparam int unsigned      SlotW        = 5;

  typedef enum logic [1:0] {
    OP_WRITE          = 2'd0,
    OP_CLEAR_COUNTERS = 2'd1,
    OP_CLEAR_SHADOW   = 2'd2,
    OP_IDLE           = 2'd3
  } op_e;

  // Update request for the counter bank
  typedef struct packed {
    logic                   clear;
    logic [NumCounters-1:0] bump;
  } cnt_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic [ChanW-1:0] chan;
  } slot_chan_t;

  // Map an operator slot to the channel that owns it
  function automatic slot_chan_t slot_channel(input logic [SlotW-1:0] slot);
    slot_chan_t r;
    r.valid = 1'b1;
    unique case (slot)
      5'd0,  5'd3:  r.chan = 4'd0;
      5'd1,  5'd4:  r.chan = 4'd1;
      5'd2,  5'd5:  r.chan = 4'd2;
      5'd8,  5'd11: r.chan = 4'd3;
      5'd9,  5'd12: r.chan = 4'd4;
      5'd10, 5'd13: r.chan = 4'd5;
      5'd16, 5'd19: r.chan = 4'd6;
      5'd17, 5'd20: r.chan = 4'd7;
      5'd18, 5'd21: r.chan = 4'd8;
      default: begin
        r.valid = 1'b0;
        r.chan  = 4'd0;
      end
    endcase
    return r;
  endfunction

  // Operator register group from the top address bits
  function automatic logic [2:0] group_of(input logic [AddrW-1:0] addr);
    logic [2:0] g;
    unique case (addr[7:5])
      3'd1:    g = 3'd0;
      3'd2:    g = 3'd1;
      3'd3:    g = 3'd2;
      3'd4:    g = 3'd3;
      default: g = 3'd4;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- src/opl2rwp_if.sv -----
// Valid/ready channel interfaces for the profiler's write input and result output.
// Depends on opl2rwp_pkg for field widths.
`default_nettype none

interface opl2rwp_in_if
  import opl2rwp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [AddrW-1:0] reg_address;
  logic [DataW-1:0] reg_data;

  modport source (output valid, output opcode, output reg_address, output reg_data,
                  input ready);
  modport sink   (input valid, input opcode, input reg_address, input reg_data,
                  output ready);
endinterface

interface opl2rwp_out_if
  import opl2rwp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 key_on_event;
  logic [ChanW-1:0]     key_on_channel;
  logic [OutCountW-1:0] note_on_count;
  logic [OutCountW-1:0] pitch_write_count;
  logic [OutCountW-1:0] live_operator_count;
  logic [OutCountW-1:0] live_multiplier_count;
  logic [OutCountW-1:0] live_level_count;
  logic [OutCountW-1:0] live_attack_decay_count;
  logic [OutCountW-1:0] live_sustain_release_count;
  logic [OutCountW-1:0] live_waveform_count;
  logic [OutCountW-1:0] rhythm_write_count;

  modport source (output valid, output key_on_event, output key_on_channel,
                  output note_on_count, output pitch_write_count,
                  output live_operator_count, output live_multiplier_count,
                  output live_level_count, output live_attack_decay_count,
                  output live_sustain_release_count, output live_waveform_count,
                  output rhythm_write_count, input ready);
  modport sink   (input valid, input key_on_event, input key_on_channel,
                  input note_on_count, input pitch_write_count,
                  input live_operator_count, input live_multiplier_count,
                  input live_level_count, input live_attack_decay_count,
                  input live_sustain_release_count, input live_waveform_count,
                  input rhythm_write_count, output ready);
endinterface

`default_nettype wire

// ----- src/opl2rwp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module opl2rwp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/opl2rwp_cnt_bank.sv -----
// Bank of saturating event counters with synchronous clear.
// Depends on opl2rwp_pkg for the counter count and the control struct.
`default_nettype none

module opl2rwp_cnt_bank
  import opl2rwp_pkg::*;
#(
  parameter int unsigned CounterBits = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire cnt_ctrl_t            ctrl_i,
  output logic      [OutCountW-1:0] count_next_o [NumCounters]
);

  localparam int unsigned ExtW = (CounterBits > OutCountW) ? CounterBits : OutCountW;

  logic [CounterBits-1:0] cnt_q [NumCounters];
  logic [CounterBits-1:0] cnt_d [NumCounters];

  for (genvar i = 0; i < NumCounters; i++) begin : g_cnt
    logic [ExtW-1:0] ext;

    always_comb begin
      cnt_d[i] = cnt_q[i];
      if (ctrl_i.clear) begin
        cnt_d[i] = '0;
      end else if (ctrl_i.bump[i] && (cnt_q[i] != {CounterBits{1'b1}})) begin
        cnt_d[i] = cnt_q[i] + CounterBits'(1);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[i] <= '0;
      end else if (en_i) begin
        cnt_q[i] <= cnt_d[i];
      end
    end

    // Report the low bits, zero-extended for narrow counters
    assign ext             = ExtW'(cnt_d[i]);
    assign count_next_o[i] = ext[OutCountW-1:0];
  end

endmodule

`default_nettype wire

// ----- src/opl2_register_write_profiler.sv -----
// The result is registered: stage 1 takes the accepted transaction and reads the shadow RAM,
// and decode and count then load the result register as stage 1 advances. Throughput: one
// transaction per cycle unless stalled; shadow-RAM read-after-write is bypassed in stage 1.
// The shadow file is one 256 x 8 RAM with one read and one write port per cycle.
// Reset: asynchronous, active low; clears valid bits, key-held flags, counters and pipeline.
// Shadow entries read as zero until written after reset or a shadow clear.
`default_nettype none

module opl2_register_write_profiler
  import opl2rwp_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  opl2rwp_in_if.sink  in_i,
  opl2rwp_out_if.source out_o
);

  // ---------------------------------------------------------------------------
  // Stage 1 register: the accepted transaction, waiting for its shadow read
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  op_e              s1_op_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [DataW-1:0] s1_data_q;

  // Bypass: the write retired at the same edge as our RAM read
  logic             byp_hit_q;
  logic [DataW-1:0] byp_data_q;

  // Per-register valid bits stand in for clearing the shadow RAM
  logic [NumRegs-1:0]     shv_q;
  logic [NumChannels-1:0] key_held_q;

  logic             out_valid_q;
  logic             s1_adv;
  logic             accept;
  logic             s1_write;
  logic [DataW-1:0] ram_rdata;
  logic [DataW-1:0] prev;

  // Advance stage 1 whenever the result register is free or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;
  assign s1_write   = s1_valid_q && (s1_op_q == OP_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_hit_q  <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      byp_hit_q  <= s1_adv && s1_write && (in_i.reg_address == s1_addr_q);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= op_e'(in_i.opcode);
      s1_addr_q  <= in_i.reg_address;
      s1_data_q  <= in_i.reg_data;
      byp_data_q <= s1_data_q;
    end
  end

  // Shadow RAM: read on accept, write when the write retires from stage 1
  opl2rwp_ram #(
    .Width (DataW),
    .Depth (NumRegs)
  ) u_shadow (
    .clk_i   (clk_i),
    .we_i    (s1_adv && s1_write),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_data_q),
    .re_i    (accept),
    .raddr_i (in_i.reg_address),
    .rdata_o (ram_rdata)
  );

  // Previous register contents: bypass first, then invalid entries read as zero
  always_comb begin
    if (byp_hit_q) begin
      prev = byp_data_q;
    end else if (shv_q[s1_addr_q]) begin
      prev = ram_rdata;
    end else begin
      prev = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode of the write in stage 1
  // ---------------------------------------------------------------------------
  logic             is_key_reg;
  logic [ChanW-1:0] key_chan;
  logic             key_on;
  logic             changed;
  logic             rhythm_hit;
  logic             pitch_hit;
  logic             op_space;
  slot_chan_t       slot_ch;
  logic             live_hit;
  logic [2:0]       grp;
  cnt_ctrl_t        cnt_ctrl;

  assign is_key_reg = (s1_addr_q >= AddrKeyLo) && (s1_addr_q <= AddrKeyHi);
  assign key_chan   = ChanW'(s1_addr_q - AddrKeyLo);
  assign key_on     = s1_write && is_key_reg && s1_data_q[KeyOnBit] && !key_held_q[key_chan];
  assign changed    = (prev != s1_data_q);
  assign rhythm_hit = s1_write && (s1_addr_q == AddrRhythm) &&
                      (((prev ^ s1_data_q) & RhythmMask) != '0);
  assign pitch_hit  = s1_write && (s1_addr_q >= AddrPitchLo) && (s1_addr_q <= AddrKeyHi) &&
                      changed;
  assign op_space   = ((s1_addr_q >= AddrOp1Lo) && (s1_addr_q <= AddrOp1Hi)) ||
                      ((s1_addr_q >= AddrOp2Lo) && (s1_addr_q <= AddrOp2Hi));
  // Slots with no owning channel never count as live
  assign slot_ch    = slot_channel(s1_addr_q[SlotW-1:0]);
  assign live_hit   = s1_write && op_space && changed && slot_ch.valid &&
                      key_held_q[slot_ch.chan];
  assign grp        = group_of(s1_addr_q);

  always_comb begin
    cnt_ctrl.clear = s1_valid_q && (s1_op_q == OP_CLEAR_COUNTERS);
    cnt_ctrl.bump  = '0;
    cnt_ctrl.bump[CntNoteOn] = key_on;
    cnt_ctrl.bump[CntPitch]  = pitch_hit;
    cnt_ctrl.bump[CntLive]   = live_hit;
    for (int g = 0; g < NumGroups; g++) begin
      cnt_ctrl.bump[CntGroup0 + g] = live_hit && (grp == 3'(g));
    end
    cnt_ctrl.bump[CntRhythm] = rhythm_hit;
  end

  // Shadow valid bits set on write, key-held flags follow the key bit; both drop on shadow clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shv_q      <= '0;
      key_held_q <= '0;
    end else if (s1_adv) begin
      if (s1_op_q == OP_CLEAR_SHADOW) begin
        shv_q      <= '0;
        key_held_q <= '0;
      end else if (s1_op_q == OP_WRITE) begin
        shv_q[s1_addr_q] <= 1'b1;
        if (is_key_reg) begin
          key_held_q[key_chan] <= s1_data_q[KeyOnBit];
        end
      end
    end
  end

  logic [OutCountW-1:0] count_next [NumCounters];

  opl2rwp_cnt_bank #(
    .CounterBits (COUNTER_BITS)
  ) u_cnt_bank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (s1_adv),
    .ctrl_i       (cnt_ctrl),
    .count_next_o (count_next)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                 ev_q;
  logic [ChanW-1:0]     ev_ch_q;
  logic [OutCountW-1:0] count_q [NumCounters];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ev_q    <= key_on;
      ev_ch_q <= key_on ? key_chan : '0;
      count_q <= count_next;
    end
  end

  assign out_o.valid                      = out_valid_q;
  assign out_o.key_on_event               = ev_q;
  assign out_o.key_on_channel             = ev_ch_q;
  assign out_o.note_on_count              = count_q[CntNoteOn];
  assign out_o.pitch_write_count          = count_q[CntPitch];
  assign out_o.live_operator_count        = count_q[CntLive];
  assign out_o.live_multiplier_count      = count_q[CntGroup0];
  assign out_o.live_level_count           = count_q[CntGroup0 + 1];
  assign out_o.live_attack_decay_count    = count_q[CntGroup0 + 2];
  assign out_o.live_sustain_release_count = count_q[CntGroup0 + 3];
  assign out_o.live_waveform_count        = count_q[CntGroup0 + 4];
  assign out_o.rhythm_write_count         = count_q[CntRhythm];

endmodule

`default_nettype wire

// ----- tb/opl2_register_write_profiler_test.sv -----
// Self-checking testbench for opl2_register_write_profiler: directed table, then random writes.
// Depends on opl2rwp_pkg and the opl2rwp_in_if / opl2rwp_out_if channel interfaces.
`default_nettype none

module opl2_register_write_profiler_test;
  import opl2rwp_pkg::*;

  localparam int unsigned TallyW      = 32;     // COUNTER_BITS of the instance
  localparam int unsigned RandomItems = 850;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;     // two-stage pipeline, plus margin

  // Operator slots of each channel: modulator, then carrier
  localparam logic [SlotW-1:0] ModSlot [NumChannels] = '{0, 1, 2, 8, 9, 10, 16, 17, 18};
  localparam logic [SlotW-1:0] CarSlot [NumChannels] = '{3, 4, 5, 11, 12, 13, 19, 20, 21};

  // One result as the profiler reports it; counts[i] follows the counter slot order
  typedef struct packed {
    logic                                   ev;
    logic [ChanW-1:0]                       ch;
    logic [NumCounters-1:0][OutCountW-1:0]  counts;
  } profile_t;

  // One row of stimulus; typed rows carry a hand-written key-on and note count,
  // and zeros marks rows whose counts must all read zero
  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    bit               typed;
    bit               zeros;
    logic             ev;
    logic [ChanW-1:0] ch;
    logic [31:0]      notes;
  } write_row_t;

  localparam int unsigned ScriptLen = 26;

  // Directed part: extremes, every opcode, slots with no channel, key edges,
  // rhythm bits outside the mask, unchanged writes and both clears
  localparam write_row_t Script [ScriptLen] = '{
    '{OP_IDLE,           8'hff, 8'hff, 1, 1, 0, 0, 0},  // idle right after reset
    '{OP_WRITE,          8'hb0, 8'h20, 1, 0, 1, 0, 1},  // key on, channel 0
    '{OP_WRITE,          8'h20, 8'hff, 0, 0, 0, 0, 0},  // modulator of held channel
    '{OP_WRITE,          8'h23, 8'h01, 0, 0, 0, 0, 0},  // carrier of held channel
    '{OP_WRITE,          8'h26, 8'h55, 0, 0, 0, 0, 0},  // slot with no channel
    '{OP_WRITE,          8'h47, 8'h3f, 0, 0, 0, 0, 0},  // slot with no channel
    '{OP_WRITE,          8'h48, 8'h3f, 0, 0, 0, 0, 0},  // channel 3, not held
    '{OP_WRITE,          8'hb3, 8'hdf, 1, 0, 0, 0, 1},  // all bits but the key bit
    '{OP_WRITE,          8'hb8, 8'h3f, 1, 0, 1, 8, 2},  // key on, channel 8
    '{OP_WRITE,          8'hb8, 8'h3f, 1, 0, 0, 0, 2},  // key already held
    '{OP_WRITE,          8'h95, 8'hff, 0, 0, 0, 0, 0},  // top of the first operator space
    '{OP_WRITE,          8'hf5, 8'hff, 0, 0, 0, 0, 0},  // top of the waveform group
    '{OP_WRITE,          8'he0, 8'h80, 0, 0, 0, 0, 0},
    '{OP_WRITE,          8'h60, 8'haa, 0, 0, 0, 0, 0},
    '{OP_WRITE,          8'h82, 8'h11, 0, 0, 0, 0, 0},
    '{OP_WRITE,          8'h83, 8'h11, 0, 0, 0, 0, 0},
    '{OP_WRITE,          8'h36, 8'h01, 0, 0, 0, 0, 0},  // slot 22, no channel
    '{OP_WRITE,          8'hbd, 8'hc0, 0, 0, 0, 0, 0},  // rhythm change outside the mask
    '{OP_WRITE,          8'hbd, 8'h3f, 0, 0, 0, 0, 0},  // rhythm change inside the mask
    '{OP_WRITE,          8'ha0, 8'h00, 0, 0, 0, 0, 0},  // pitch write with no change
    '{OP_WRITE,          8'h00, 8'hff, 0, 0, 0, 0, 0},
    '{OP_WRITE,          8'hff, 8'hff, 0, 0, 0, 0, 0},
    '{OP_CLEAR_COUNTERS, 8'h00, 8'h00, 1, 1, 0, 0, 0},
    '{OP_CLEAR_SHADOW,   8'hff, 8'hff, 0, 0, 0, 0, 0},
    '{OP_WRITE,          8'hb8, 8'h20, 1, 0, 1, 8, 1},  // held flags were cleared
    '{OP_WRITE,          8'h23, 8'h01, 0, 0, 0, 0, 0}   // channel 0 no longer held
  };

  logic clk_i;
  logic rst_ni;
  bit   calm;   // no idling on either side while set

  opl2rwp_in_if  wr_bus ();
  opl2rwp_out_if prof_bus ();

  opl2_register_write_profiler #(
    .COUNTER_BITS(TallyW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (wr_bus),
    .out_o (prof_bus)
  );

  // Predictor state: register copy, held keys and event tallies
  logic [DataW-1:0]  shadow_copy [NumRegs];
  logic              key_down    [NumChannels];
  logic [TallyW-1:0] event_tally [NumCounters];

  profile_t pending_results [$];
  int       mismatches;
  int       sent;
  int       checked;
  int       key_ons;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void bump_tally(int unsigned idx);
    if (event_tally[idx] != '1) event_tally[idx]++;
  endfunction

  function automatic int unsigned reg_group(logic [AddrW-1:0] addr);
    case (addr[7:5])
      3'd1:    return 0;
      3'd2:    return 1;
      3'd3:    return 2;
      3'd4:    return 3;
      default: return 4;
    endcase
  endfunction

  // Apply one transaction to the predictor state and return the result it causes
  function automatic profile_t apply_write(op_e op, logic [AddrW-1:0] addr,
                                           logic [DataW-1:0] data);
    profile_t         r;
    logic [DataW-1:0] prev;
    int unsigned      ch;
    logic [SlotW-1:0] slot;
    r = '0;
    case (op)
      OP_CLEAR_COUNTERS: begin
        foreach (event_tally[i]) event_tally[i] = '0;
      end
      OP_CLEAR_SHADOW: begin
        foreach (shadow_copy[i]) shadow_copy[i] = '0;
        foreach (key_down[i]) key_down[i] = 1'b0;
      end
      OP_WRITE: begin
        prev = shadow_copy[addr];
        shadow_copy[addr] = data;
        if (addr >= AddrKeyLo && addr <= AddrKeyHi) begin
          ch = {24'd0, addr - AddrKeyLo};
          // rising edge of the key bit only
          if (data[KeyOnBit] && !key_down[ch]) begin
            bump_tally(CntNoteOn);
            r.ev = 1'b1;
            r.ch = ch[ChanW-1:0];
          end
          key_down[ch] = data[KeyOnBit];
        end
        if (addr == AddrRhythm && ((prev ^ data) & RhythmMask) != '0) bump_tally(CntRhythm);
        if (addr >= AddrPitchLo && addr <= AddrKeyHi && prev != data) bump_tally(CntPitch);
        if (((addr >= AddrOp1Lo && addr <= AddrOp1Hi) ||
             (addr >= AddrOp2Lo && addr <= AddrOp2Hi)) && prev != data) begin
          slot = addr[SlotW-1:0];
          for (int c = 0; c < NumChannels; c++) begin
            if (key_down[c] && (slot == ModSlot[c] || slot == CarSlot[c])) begin
              bump_tally(CntLive);
              bump_tally(CntGroup0 + reg_group(addr));
            end
          end
        end
      end
      default: ;  // unused opcode: no change
    endcase
    for (int i = 0; i < NumCounters; i++) r.counts[i] = event_tally[i][OutCountW-1:0];
    return r;
  endfunction

  // Drive one transaction from a falling edge, hold it until accepted,
  // then log the expected result and return at the next falling edge
  task automatic issue_write(input write_row_t row);
    profile_t want;
    while (!calm && $urandom_range(0, 99) < 8) begin
      wr_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    wr_bus.valid       <= 1'b1;
    wr_bus.opcode      <= row.op;
    wr_bus.reg_address <= row.addr;
    wr_bus.reg_data    <= row.data;
    do @(posedge clk_i); while (!wr_bus.ready);
    want = apply_write(row.op, row.addr, row.data);
    if (row.typed) begin
      want.ev = row.ev;
      want.ch = row.ch;
      want.counts[CntNoteOn] = row.notes;
    end
    if (row.zeros) want.counts = '0;
    pending_results.push_back(want);
    sent++;
    @(negedge clk_i);
  endtask

  // Result side: stall at random, changing only on falling edges
  initial prof_bus.ready = 1'b0;
  always @(negedge clk_i) begin
    prof_bus.ready <= calm || ($urandom_range(0, 99) >= 8);
  end

  // Compare each result with the oldest expectation, field by field
  always @(posedge clk_i) begin : check_results
    profile_t got;
    profile_t want;
    string    names [NumCounters];
    names = '{"note_on_count", "pitch_write_count", "live_operator_count",
              "live_multiplier_count", "live_level_count", "live_attack_decay_count",
              "live_sustain_release_count", "live_waveform_count", "rhythm_write_count"};
    if (rst_ni && prof_bus.valid && prof_bus.ready) begin
      got.ev = prof_bus.key_on_event;
      got.ch = prof_bus.key_on_channel;
      got.counts[CntNoteOn]   = prof_bus.note_on_count;
      got.counts[CntPitch]    = prof_bus.pitch_write_count;
      got.counts[CntLive]     = prof_bus.live_operator_count;
      got.counts[CntGroup0]   = prof_bus.live_multiplier_count;
      got.counts[CntGroup0+1] = prof_bus.live_level_count;
      got.counts[CntGroup0+2] = prof_bus.live_attack_decay_count;
      got.counts[CntGroup0+3] = prof_bus.live_sustain_release_count;
      got.counts[CntGroup0+4] = prof_bus.live_waveform_count;
      got.counts[CntRhythm]   = prof_bus.rhythm_write_count;
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got.ev === 1'b1) key_ons++;
        if (got.ev !== want.ev) begin
          $error("key_on_event: expected %0d, got %0d", want.ev, got.ev);
          mismatches++;
        end
        if (got.ch !== want.ch) begin
          $error("key_on_channel: expected %0d, got %0d", want.ch, got.ch);
          mismatches++;
        end
        for (int i = 0; i < NumCounters; i++) begin
          if (got.counts[i] !== want.counts[i]) begin
            $error("%s: expected %0d, got %0d", names[i], want.counts[i], got.counts[i]);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    write_row_t       row;
    int unsigned      pick;
    int unsigned      c;
    logic [SlotW-1:0] slot;
    mismatches = 0;
    sent       = 0;
    checked    = 0;
    key_ons    = 0;
    calm       = 1'b0;
    foreach (shadow_copy[i]) shadow_copy[i] = '0;
    foreach (key_down[i]) key_down[i] = 1'b0;
    foreach (event_tally[i]) event_tally[i] = '0;
    wr_bus.valid       = 1'b0;
    wr_bus.opcode      = OP_WRITE;
    wr_bus.reg_address = '0;
    wr_bus.reg_data    = '0;
    rst_ni             = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (Script[i]) issue_write(Script[i]);

    // Random part: mostly key, operator and pitch traffic so that held
    // channels see live edits; a little noise, clears and idle opcodes
    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 300 && n < 450);
      pick = $urandom_range(0, 99);
      row = '0;
      row.op   = OP_WRITE;
      row.addr = AddrW'($urandom_range(0, 255));
      row.data = DataW'($urandom_range(0, 255));
      if (pick < 2) begin
        row.op = OP_CLEAR_COUNTERS;
      end else if (pick < 3) begin
        row.op = OP_CLEAR_SHADOW;
      end else if (pick < 4) begin
        row.op = OP_IDLE;
      end else if (pick < 30) begin
        row.addr = AddrKeyLo + AddrW'($urandom_range(0, 8));
        row.data[KeyOnBit] = 1'($urandom_range(0, 1));
      end else if (pick < 70) begin
        if ($urandom_range(0, 99) < 85) begin
          c = $urandom_range(0, NumChannels - 1);
          slot = $urandom_range(0, 1) ? ModSlot[c] : CarSlot[c];
        end else begin
          // slots with no channel
          case ($urandom_range(0, 4))
            0:       slot = 5'd6;
            1:       slot = 5'd7;
            2:       slot = 5'd14;
            3:       slot = 5'd15;
            default: slot = SlotW'($urandom_range(22, 31));
          endcase
        end
        case ($urandom_range(0, 4))
          0:       row.addr = 8'h20;
          1:       row.addr = 8'h40;
          2:       row.addr = 8'h60;
          3:       row.addr = 8'h80;
          default: row.addr = AddrOp2Lo;
        endcase
        row.addr[SlotW-1:0] = slot;
      end else if (pick < 80) begin
        row.addr = AddrPitchLo + AddrW'($urandom_range(0, 24));
      end else if (pick < 86) begin
        row.addr = AddrRhythm;
      end
      // rewrite the current value now and then: such writes must not count
      if (row.op == OP_WRITE && $urandom_range(0, 4) == 0) row.data = shadow_copy[row.addr];
      issue_write(row);
    end
    calm = 1'b0;
    wr_bus.valid <= 1'b0;

    // Drain, then watch a little longer for stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d transactions (%0d from the directed table), checked %0d results.",
             sent, ScriptLen, checked);
    $display("Results reported %0d key-on edges; %0d mismatches.", key_ons, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
